### hw/rtl/cssd_pkg.sv
`timescale 1ns / 1ps

package cssd_pkg;

  // Field widths
  localparam int EN_W        = 16;
  localparam int POS_W       = 16;
  localparam int RATIO_W     = 12;
  localparam int MERGE_W     = 32;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int FRAC_BITS   = 8;

  // Window geometry
  localparam int HALF_WINDOW = 3;
  localparam int WIN_LEN     = 2 * HALF_WINDOW;
  localparam int HITS_W      = $clog2(WIN_LEN + 1);
  localparam int SUM_W       = EN_W + $clog2(HALF_WINDOW + 1);

  // Arithmetic widths
  localparam int PROD_W      = SUM_W + RATIO_W;
  localparam int CMP_W       = 2 * SUM_W;
  localparam int DIFF_W      = POS_W + 1;
  localparam int SQ_W        = 2 * POS_W;
  localparam int DSQ_W       = SQ_W + 2;

  // Queue between front and back
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_RATIO = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MERGE = 1'd1;
  localparam logic [RATIO_W-1:0]   RATIO_RESET = 12'd384;
  localparam logic [MERGE_W-1:0]   MERGE_RESET = 32'd256;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos_t;

  typedef struct packed {
    logic                    first_of_cluster;
    logic [EN_W-1:0]         hit_energy;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] split_x;
    logic signed [POS_W-1:0] split_y;
    logic signed [POS_W-1:0] split_z;
  } out_item_t;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic [MERGE_W-1:0] merge;
  } cfg_t;

  // One classified window handed from front to back
  typedef struct packed {
    logic             first;
    logic             full;
    logic             pvalid;
    logic [SUM_W-1:0] b_sum;
    logic [SUM_W-1:0] a_sum;
    logic [SUM_W-1:0] pb_sum;
    logic [SUM_W-1:0] pa_sum;
    pos_t             pos;
  } job_t;

endpackage

### hw/rtl/charge_step_split_detector.sv
`timescale 1ns / 1ps
// Charge step split detector.
// Input channel (in_valid, in_stall, in_data): one hit per transaction, hits of
// a cluster in order, first_of_cluster set on each cluster's first hit.
// Output channel (out_valid, out_stall, out_data): one split position per
// transaction, given for windows whose middle hit shows an energy step.
// Config port (cfg_we, cfg_index, cfg_data): index 0 step ratio (Q4.8),
// index 1 squared merge distance; write only while the block is idle.
// Throughput: one hit per cycle while out_stall stays low. The front classifies a
// hit in its accept cycle; a 4-entry queue feeds a 4-stage back end (products, split
// decision, squares, merge choice into the output register).
// An accepted hit goes into the queue, then through stages 1 to 3 to the output register.
// Out stall freezes the back end; the queue absorbs up to 4 more hits, then
// in_stall rises until the result is taken.
// Reset (rst_n low at a clock edge): registers back to 384 and 256, window and
// split history cleared, queue and pipeline emptied.
module charge_step_split_detector (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  cssd_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output cssd_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [cssd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cssd_pkg::CFG_W-1:0]          cfg_data
);

  cssd_pkg::cfg_t cfg_r;
  cssd_pkg::job_t push_job, head_job;
  logic           push, pop, q_full, q_empty;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ratio <= cssd_pkg::RATIO_RESET;
      cfg_r.merge <= cssd_pkg::MERGE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cssd_pkg::REG_RATIO: cfg_r.ratio <= cfg_data[cssd_pkg::RATIO_W-1:0];
        cssd_pkg::REG_MERGE: cfg_r.merge <= cfg_data[cssd_pkg::MERGE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;

  cssd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  cssd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_full   (q_full),
    .q_empty  (q_empty)
  );

  cssd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head_job  (head_job),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

### hw/rtl/cssd_front.sv
`timescale 1ns / 1ps

module cssd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  cssd_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              push,
  output cssd_pkg::job_t    job
);

  logic [cssd_pkg::EN_W-1:0]   ew_r [cssd_pkg::WIN_LEN];
  cssd_pkg::pos_t              ctr_r [cssd_pkg::HALF_WINDOW];
  logic [cssd_pkg::HITS_W-1:0] hits_r, hits_nxt, hits_eff;
  logic [cssd_pkg::SUM_W-1:0]  pb_r, pa_r, b_sum, a_sum;
  logic                        pvalid_r;
  logic                        first, full;

  assign push  = in_valid && !q_full;
  assign first = in_data.first_of_cluster;

  // Window state as seen by this hit: a cluster start empties it
  assign hits_eff = first ? '0 : hits_r;
  assign full     = hits_eff >= cssd_pkg::HITS_W'(cssd_pkg::WIN_LEN);
  assign hits_nxt = full ? hits_eff : hits_eff + 1'b1;

  // Before and after sums around the middle hit
  always_comb begin
    b_sum = '0;
    a_sum = cssd_pkg::SUM_W'(in_data.hit_energy);
    for (int i = 0; i < cssd_pkg::HALF_WINDOW; i++) begin
      b_sum = b_sum + cssd_pkg::SUM_W'(ew_r[i]);
    end
    for (int i = cssd_pkg::HALF_WINDOW + 1; i < cssd_pkg::WIN_LEN; i++) begin
      a_sum = a_sum + cssd_pkg::SUM_W'(ew_r[i]);
    end
  end

  always_comb begin
    job.first  = first;
    job.full   = full;
    job.pvalid = first ? 1'b0 : pvalid_r;
    job.b_sum  = b_sum;
    job.a_sum  = a_sum;
    job.pb_sum = first ? '0 : pb_r;
    job.pa_sum = first ? cssd_pkg::SUM_W'(1) : pa_r;
    job.pos    = ctr_r[0];
  end

  // Cluster control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r   <= '0;
      pvalid_r <= 1'b0;
      pb_r     <= '0;
      pa_r     <= cssd_pkg::SUM_W'(1);
    end else if (push) begin
      hits_r <= hits_nxt;
      if (full) begin
        pvalid_r <= 1'b1;
        pb_r     <= b_sum;
        pa_r     <= a_sum;
      end else if (first) begin
        pvalid_r <= 1'b0;
        pb_r     <= '0;
        pa_r     <= cssd_pkg::SUM_W'(1);
      end
    end
  end

  // Energy and position shift lines; entries are refilled before use
  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < cssd_pkg::WIN_LEN - 1; i++) begin
        ew_r[i] <= ew_r[i+1];
      end
      ew_r[cssd_pkg::WIN_LEN-1] <= in_data.hit_energy;
      for (int i = 0; i < cssd_pkg::HALF_WINDOW - 1; i++) begin
        ctr_r[i] <= ctr_r[i+1];
      end
      ctr_r[cssd_pkg::HALF_WINDOW-1] <= '{x: in_data.pos_x, y: in_data.pos_y, z: in_data.pos_z};
    end
  end

endmodule

### hw/rtl/cssd_queue.sv
`timescale 1ns / 1ps

module cssd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cssd_pkg::job_t push_job,
  input  logic           pop,
  output cssd_pkg::job_t head_job,
  output logic           q_full,
  output logic           q_empty
);

  cssd_pkg::job_t               mem_r [cssd_pkg::FIFO_DEPTH];
  logic [cssd_pkg::FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [cssd_pkg::FIFO_CW-1:0] count_r;

  assign q_full   = count_r == cssd_pkg::FIFO_CW'(cssd_pkg::FIFO_DEPTH);
  assign q_empty  = count_r == '0;
  assign head_job = mem_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == cssd_pkg::FIFO_AW'(cssd_pkg::FIFO_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == cssd_pkg::FIFO_AW'(cssd_pkg::FIFO_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cssd_pkg::FIFO_CW'(cssd_pkg::FIFO_DEPTH))
    else $error("queue fill count above depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("queue popped while empty");

endmodule

### hw/rtl/cssd_back.sv
`timescale 1ns / 1ps

module cssd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  cssd_pkg::cfg_t      cfg,
  input  cssd_pkg::job_t      head_job,
  input  logic                q_empty,
  output logic                pop,
  output logic                out_valid,
  output cssd_pkg::out_item_t out_data,
  input  logic                out_stall
);

  logic en;

  // Stage 1: step products and absolute differences
  logic                        s1_v_r, s1_first_r, s1_full_r, s1_pvalid_r;
  logic [cssd_pkg::SUM_W-1:0]  s1_b_r, s1_a_r, s1_pa_r, s1_d1_r, s1_d2_r;
  logic [cssd_pkg::PROD_W-1:0] s1_br_r, s1_ra_r;
  cssd_pkg::pos_t              s1_pos_r;

  // Stage 2: split decision, running split position, ratio products
  logic                        s2_v_r, s2_emit_r, s2_pvalid_r;
  cssd_pkg::pos_t              s2_pos_r, s2_prev_r;
  logic signed [cssd_pkg::DIFF_W-1:0] s2_dx_r, s2_dy_r, s2_dz_r;
  logic signed [cssd_pkg::DIFF_W-1:0] dx_nxt, dy_nxt, dz_nxt;
  logic [cssd_pkg::CMP_W-1:0]  s2_lhs_r, s2_rhs_r;
  cssd_pkg::pos_t              cur_r, cur_eff;
  logic                        found;

  // Stage 3: squared distances and ratio compare
  logic                        s3_v_r, s3_emit_r, s3_pvalid_r, s3_gt_r;
  cssd_pkg::pos_t              s3_pos_r, s3_prev_r;
  logic [cssd_pkg::SQ_W-1:0]   s3_sqx_r, s3_sqy_r, s3_sqz_r;
  logic signed [2*cssd_pkg::DIFF_W-1:0] sqx_full, sqy_full, sqz_full;

  // Output register
  logic                        out_valid_r;
  cssd_pkg::out_item_t         out_data_r;
  logic [cssd_pkg::DSQ_W-1:0]  dsq;
  logic                        far;
  cssd_pkg::pos_t              chosen;

  assign en  = !out_valid_r || !out_stall;
  assign pop = en && !q_empty;

  // Stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_first_r  <= head_job.first;
      s1_full_r   <= head_job.full;
      s1_pvalid_r <= head_job.pvalid;
      s1_b_r      <= head_job.b_sum;
      s1_a_r      <= head_job.a_sum;
      s1_pa_r     <= head_job.pa_sum;
      s1_pos_r    <= head_job.pos;
      s1_br_r     <= cssd_pkg::PROD_W'(head_job.b_sum) * cssd_pkg::PROD_W'(cfg.ratio);
      s1_ra_r     <= cssd_pkg::PROD_W'(head_job.a_sum) * cssd_pkg::PROD_W'(cfg.ratio);
      s1_d1_r     <= (head_job.b_sum > head_job.a_sum) ?
                     head_job.b_sum - head_job.a_sum : head_job.a_sum - head_job.b_sum;
      s1_d2_r     <= (head_job.pb_sum > head_job.pa_sum) ?
                     head_job.pb_sum - head_job.pa_sum : head_job.pa_sum - head_job.pb_sum;
    end
  end

  // Stage 2: a step either way is a split
  assign found = ((cssd_pkg::PROD_W'(s1_b_r) << cssd_pkg::FRAC_BITS) > s1_ra_r) ||
                 (s1_br_r < (cssd_pkg::PROD_W'(s1_a_r) << cssd_pkg::FRAC_BITS));

  // Last split position of this cluster, cleared at a cluster start
  assign cur_eff = s1_first_r ? '0 : cur_r;

  assign dx_nxt = $signed({s1_pos_r.x[cssd_pkg::POS_W-1], s1_pos_r.x}) -
                  $signed({cur_eff.x[cssd_pkg::POS_W-1], cur_eff.x});
  assign dy_nxt = $signed({s1_pos_r.y[cssd_pkg::POS_W-1], s1_pos_r.y}) -
                  $signed({cur_eff.y[cssd_pkg::POS_W-1], cur_eff.y});
  assign dz_nxt = $signed({s1_pos_r.z[cssd_pkg::POS_W-1], s1_pos_r.z}) -
                  $signed({cur_eff.z[cssd_pkg::POS_W-1], cur_eff.z});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      cur_r  <= '0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
      if (s1_v_r) begin
        cur_r <= (s1_full_r && found) ? s1_pos_r : cur_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_emit_r   <= s1_full_r && found;
      s2_pvalid_r <= s1_pvalid_r;
      s2_pos_r    <= s1_pos_r;
      s2_prev_r   <= cur_eff;
      s2_dx_r     <= dx_nxt;
      s2_dy_r     <= dy_nxt;
      s2_dz_r     <= dz_nxt;
      s2_lhs_r    <= cssd_pkg::CMP_W'(s1_d1_r) * cssd_pkg::CMP_W'(s1_pa_r);
      s2_rhs_r    <= cssd_pkg::CMP_W'(s1_d2_r) * cssd_pkg::CMP_W'(s1_a_r);
    end
  end

  // Stage 3
  assign sqx_full = s2_dx_r * s2_dx_r;
  assign sqy_full = s2_dy_r * s2_dy_r;
  assign sqz_full = s2_dz_r * s2_dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_emit_r   <= s2_emit_r;
      s3_pvalid_r <= s2_pvalid_r;
      s3_pos_r    <= s2_pos_r;
      s3_prev_r   <= s2_prev_r;
      s3_gt_r     <= s2_lhs_r > s2_rhs_r;
      s3_sqx_r    <= sqx_full[cssd_pkg::SQ_W-1:0];
      s3_sqy_r    <= sqy_full[cssd_pkg::SQ_W-1:0];
      s3_sqz_r    <= sqz_full[cssd_pkg::SQ_W-1:0];
    end
  end

  // Merge rule: near splits keep the one further from a unit ratio
  assign dsq    = cssd_pkg::DSQ_W'(s3_sqx_r) + cssd_pkg::DSQ_W'(s3_sqy_r) +
                  cssd_pkg::DSQ_W'(s3_sqz_r);
  assign far    = !s3_pvalid_r || (dsq >= cssd_pkg::DSQ_W'(cfg.merge));
  assign chosen = (far || s3_gt_r) ? s3_pos_r : s3_prev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s3_v_r && s3_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= '{split_x: chosen.x, split_y: chosen.y, split_z: chosen.z};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_cur_tracks_split: assert property (@(posedge clk) disable iff (!rst_n)
    en && s1_v_r && s1_full_r && found |=> cur_r == $past(s1_pos_r))
    else $error("split position not captured");

  a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable({s1_v_r, s2_v_r, s3_v_r}))
    else $error("pipeline moved while output stalled");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s3_v_r && s3_emit_r))
    else $error("result without an emitting window");

endmodule

### bench/charge_step_split_detector_test.sv
`timescale 1ns / 1ps

module charge_step_split_detector_test;

  localparam int QUIET_LIMIT   = 5000;  // cycles with no transaction on either side
  localparam int SETTLE_CYCLES = 12;    // back end is 4 deep, plus margin
  localparam int HOLD_CYCLES   = 150;   // long receiver hold-off
  localparam int PHASE_HITS    = 225;

  typedef enum logic [1:0] {
    CHECK_MODEL,  // expectation comes from the split predictor
    CHECK_NONE,   // no split allowed for this hit
    CHECK_AT      // split expected at a typed-in position
  } check_t;

  typedef struct {
    cssd_pkg::in_item_t  hit;
    check_t              check_by;
    cssd_pkg::out_item_t want;
  } hit_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  cssd_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  cssd_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [cssd_pkg::CFG_IDX_W-1:0] cfg_index = cssd_pkg::REG_RATIO;
  logic [cssd_pkg::CFG_W-1:0] cfg_data = '0;

  charge_step_split_detector DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Split predictor state
  logic [cssd_pkg::EN_W-1:0]    win_energy [cssd_pkg::WIN_LEN];
  cssd_pkg::pos_t               centers [cssd_pkg::HALF_WINDOW];
  int unsigned                  win_fill;
  cssd_pkg::pos_t               split_now;
  cssd_pkg::pos_t               split_last;
  bit                           split_last_ok;
  longint unsigned              last_before;
  longint unsigned              last_after;
  logic [cssd_pkg::RATIO_W-1:0] ratio_q8 = cssd_pkg::RATIO_RESET;
  logic [cssd_pkg::MERGE_W-1:0] merge_sq = cssd_pkg::MERGE_RESET;

  function automatic void clear_history();
    for (int i = 0; i < cssd_pkg::WIN_LEN; i++) win_energy[i] = '0;
    for (int i = 0; i < cssd_pkg::HALF_WINDOW; i++) centers[i] = '0;
    win_fill = 0;
    split_now = '0;
    split_last = '0;
    split_last_ok = 1'b0;
    last_before = 0;
    last_after = 1;
  endfunction

  function automatic longint unsigned gap(longint unsigned a, longint unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic longint unsigned axis_sq(logic signed [cssd_pkg::POS_W-1:0] a,
                                              logic signed [cssd_pkg::POS_W-1:0] b);
    longint signed d;
    d = longint'(a) - longint'(b);
    return longint'(d * d);
  endfunction

  // Advances the predictor by one hit; returns 1 when a split position comes out
  function automatic bit predict_split(input cssd_pkg::in_item_t h,
                                       output cssd_pkg::out_item_t split);
    longint unsigned prior;
    longint unsigned after;
    longint unsigned dsq;
    bit found;
    bit far;
    cssd_pkg::pos_t chosen;
    found = 1'b0;
    split = '0;
    if (h.first_of_cluster) clear_history();
    if (win_fill >= cssd_pkg::WIN_LEN) begin
      prior = 0;
      after = h.hit_energy;
      for (int i = 0; i < cssd_pkg::HALF_WINDOW; i++) prior += win_energy[i];
      for (int i = cssd_pkg::HALF_WINDOW + 1; i < cssd_pkg::WIN_LEN; i++) begin
        after += win_energy[i];
      end
      found = (prior * 256 > ratio_q8 * after) || (prior * ratio_q8 < after * 256);
      if (found) begin
        split_now = centers[0];
        far = 1'b1;
        if (split_last_ok) begin
          dsq = axis_sq(split_now.x, split_last.x) + axis_sq(split_now.y, split_last.y)
              + axis_sq(split_now.z, split_last.z);
          far = dsq >= longint'(merge_sq);
        end
        chosen = split_now;
        // near the last split: keep the one whose ratio is further from 1
        if (!far && !(gap(prior, after) * last_after > gap(last_before, last_after) * after))
          chosen = split_last;
        split.split_x = chosen.x;
        split.split_y = chosen.y;
        split.split_z = chosen.z;
      end
      split_last = split_now;
      split_last_ok = 1'b1;
      last_before = prior;
      last_after = after;
    end
    for (int i = 0; i + 1 < cssd_pkg::WIN_LEN; i++) win_energy[i] = win_energy[i + 1];
    win_energy[cssd_pkg::WIN_LEN - 1] = h.hit_energy;
    for (int i = 0; i + 1 < cssd_pkg::HALF_WINDOW; i++) centers[i] = centers[i + 1];
    centers[cssd_pkg::HALF_WINDOW - 1] = '{x: h.pos_x, y: h.pos_y, z: h.pos_z};
    if (win_fill < cssd_pkg::WIN_LEN) win_fill++;
    return found;
  endfunction

  // Stimulus and bookkeeping
  hit_req_t            hit_queue [$];
  cssd_pkg::out_item_t expected_splits [$];
  hit_req_t            drive_req;
  int                  hits_sent = 0;
  int                  hits_taken = 0;
  int                  fail_count = 0;
  int                  send_idle_pct = 0;
  int                  stall_pct = 0;
  int                  holds_asked = 0;
  int                  holds_done = 0;
  int                  hold_left = 0;
  int                  quiet_cycles = 0;
  bit                  split_made;
  cssd_pkg::out_item_t split_guess;
  cssd_pkg::out_item_t split_want;

  // Sender: a payload stays put while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (hit_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drive_req <= hit_queue[0];
        in_data <= hit_queue[0].hit;
        in_valid <= 1'b1;
        void'(hit_queue.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall, or a long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Predict on each input transaction, check each output transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        hits_taken++;
        split_made = predict_split(drive_req.hit, split_guess);
        case (drive_req.check_by)
          CHECK_MODEL: if (split_made) expected_splits = {expected_splits, split_guess};
          CHECK_AT:    expected_splits = {expected_splits, drive_req.want};
          default:     ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_splits.size() == 0) begin
          $error("unexpected split at (%0d, %0d, %0d)",
                 out_data.split_x, out_data.split_y, out_data.split_z);
          fail_count++;
        end else begin
          split_want = expected_splits.pop_front();
          if (out_data.split_x !== split_want.split_x) begin
            $error("split_x: expected %0d, got %0d", split_want.split_x, out_data.split_x);
            fail_count++;
          end
          if (out_data.split_y !== split_want.split_y) begin
            $error("split_y: expected %0d, got %0d", split_want.split_y, out_data.split_y);
            fail_count++;
          end
          if (out_data.split_z !== split_want.split_z) begin
            $error("split_z: expected %0d, got %0d", split_want.split_z, out_data.split_z);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("charge_step_split_detector_test: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic hit_req_t row(bit first, int e, int x, int y, int z, check_t how,
                                   int wx = 0, int wy = 0, int wz = 0);
    hit_req_t r;
    r.hit = '{first_of_cluster: first, hit_energy: cssd_pkg::EN_W'(e),
              pos_x: cssd_pkg::POS_W'(x),
              pos_y: cssd_pkg::POS_W'(y),
              pos_z: cssd_pkg::POS_W'(z)};
    r.check_by = how;
    r.want = '{split_x: cssd_pkg::POS_W'(wx), split_y: cssd_pkg::POS_W'(wy),
               split_z: cssd_pkg::POS_W'(wz)};
    return r;
  endfunction

  task automatic write_reg(input logic [cssd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cssd_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == cssd_pkg::REG_RATIO) ratio_q8 = data[cssd_pkg::RATIO_W-1:0];
    else merge_sq = data[cssd_pkg::MERGE_W-1:0];
  endtask

  // Block is idle once every hit is in, every split is out and the back end is empty
  task automatic settle();
    while (hits_taken != hits_sent || expected_splits.size() != 0) @(posedge clk);
    stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [cssd_pkg::EN_W-1:0] next_level();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return cssd_pkg::EN_W'($urandom_range(0, 255));
      3:       return cssd_pkg::EN_W'($urandom_range(1000, 3000));
      default: return cssd_pkg::EN_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Clusters of hits with energy steps and a slowly wandering position
  task automatic queue_random_hits(input int count);
    int made;
    int len;
    logic [cssd_pkg::EN_W-1:0] level;
    logic [95:0] noise;
    cssd_pkg::pos_t at;
    hit_req_t req;
    made = 0;
    while (made < count) begin
      case ($urandom_range(0, 9))
        0:       len = $urandom_range(1, 6);
        9:       len = $urandom_range(21, 40);
        default: len = $urandom_range(7, 20);
      endcase
      noise = {$urandom, $urandom, $urandom};
      at = noise[47:0];
      level = next_level();
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 3) == 0) level = next_level();
        if ($urandom_range(0, 19) == 0) begin
          noise = {$urandom, $urandom, $urandom};
          at = noise[47:0];
        end else begin
          at.x = at.x + cssd_pkg::POS_W'($urandom_range(0, 14)) - cssd_pkg::POS_W'(7);
          at.y = at.y + cssd_pkg::POS_W'($urandom_range(0, 14)) - cssd_pkg::POS_W'(7);
          at.z = at.z + cssd_pkg::POS_W'($urandom_range(0, 14)) - cssd_pkg::POS_W'(7);
        end
        req.check_by = CHECK_MODEL;
        req.want = '0;
        req.hit.first_of_cluster = (i == 0) ? ($urandom_range(0, 15) != 0)
                                            : ($urandom_range(0, 63) == 0);
        req.hit.hit_energy = (level < 16'hFFE0) ?
                             level + cssd_pkg::EN_W'($urandom_range(0, 31)) : level;
        req.hit.pos_x = at.x;
        req.hit.pos_y = at.y;
        req.hit.pos_z = at.z;
        // occasional fully random hit
        if ($urandom_range(0, 29) == 0) begin
          noise = {$urandom, $urandom, $urandom};
          req.hit = noise[64:0];
        end
        hit_queue = {hit_queue, req};
        hits_sent++;
        made++;
      end
    end
  endtask

  hit_req_t steps_tab [25];

  initial begin
    clear_history();
    // energy cliff right after reset with no start flag, then a zero cluster,
    // a short cluster and a flat cluster
    steps_tab = '{
      row(0, 65535, -32768, -32768, -32768, CHECK_NONE),
      row(0, 65535,  32767,  32767,  32767, CHECK_NONE),
      row(0, 65535,      0,      0,      0, CHECK_NONE),
      row(0,     0,  32767, -32768,      1, CHECK_NONE),
      row(0,     0,     -1,      2,     -3, CHECK_NONE),
      row(0,     0,      4,     -5,      6, CHECK_NONE),
      row(0,     0,      7,      8,      9, CHECK_AT, 32767, -32768, 1),
      row(0,     0,     10,     11,     12, CHECK_MODEL),
      row(1,     0,    100,    100,    100, CHECK_NONE),
      row(0,     0,    101,    100,    100, CHECK_NONE),
      row(0,     0,    102,    100,    100, CHECK_NONE),
      row(0,     0,    103,    100,    100, CHECK_NONE),
      row(0,     0,    104,    100,    100, CHECK_NONE),
      row(0,     0,    105,    100,    100, CHECK_NONE),
      row(0,     0,    106,    100,    100, CHECK_NONE),
      row(1,   500,    -50,    -50,    -50, CHECK_NONE),
      row(0,   500,    -51,    -50,    -50, CHECK_NONE),
      row(0,   500,    -52,    -50,    -50, CHECK_NONE),
      row(1,  1000,    200,   -200,      0, CHECK_NONE),
      row(0,  1000,    201,   -201,      0, CHECK_NONE),
      row(0,  1000,    202,   -202,      0, CHECK_NONE),
      row(0,  1000,    203,   -203,      0, CHECK_NONE),
      row(0,  1000,    204,   -204,      0, CHECK_NONE),
      row(0,  1000,    205,   -205,      0, CHECK_NONE),
      row(0,  1000,    206,   -206,      0, CHECK_NONE)
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pass at reset settings, no idling
    foreach (steps_tab[i]) begin
      hit_queue = {hit_queue, steps_tab[i]};
      hits_sent++;
    end
    settle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(cssd_pkg::REG_RATIO, cssd_pkg::CFG_W'(4095));
          write_reg(cssd_pkg::REG_MERGE, cssd_pkg::CFG_W'(0));
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          write_reg(cssd_pkg::REG_RATIO, cssd_pkg::CFG_W'(0));
          write_reg(cssd_pkg::REG_MERGE, '1);
          send_idle_pct = 63;
          stall_pct = 0;
        end
        2: begin
          write_reg(cssd_pkg::REG_RATIO, cssd_pkg::CFG_W'(256));
          write_reg(cssd_pkg::REG_MERGE, cssd_pkg::CFG_W'(256));
          send_idle_pct = 0;
          stall_pct = 63;
        end
        3: begin
          // upper data bits are junk for the ratio register
          write_reg(cssd_pkg::REG_RATIO, $urandom);
          write_reg(cssd_pkg::REG_MERGE, cssd_pkg::CFG_W'($urandom_range(0, 4096)));
          send_idle_pct = 20;
          stall_pct = 20;
        end
        4: begin
          write_reg(cssd_pkg::REG_RATIO, cssd_pkg::CFG_W'(cssd_pkg::RATIO_RESET));
          write_reg(cssd_pkg::REG_MERGE, cssd_pkg::CFG_W'(64));
          send_idle_pct = 0;
          stall_pct = 0;
        end
        default: begin
          write_reg(cssd_pkg::REG_RATIO, cssd_pkg::CFG_W'($urandom_range(0, 4095)));
          write_reg(cssd_pkg::REG_MERGE, $urandom);
          send_idle_pct = 20;
          stall_pct = 63;
        end
      endcase
      queue_random_hits(PHASE_HITS);
      if (phase == 4) begin
        // receiver holds off while hits keep coming, so the input backs up
        repeat (20) @(posedge clk);
        holds_asked++;
      end
      settle();
    end

    if (fail_count == 0 && expected_splits.size() == 0) begin
      $display("charge_step_split_detector_test: PASS");
    end else begin
      $display("charge_step_split_detector_test: FAIL");
    end
    $finish;
  end

endmodule
